// ===== rtl/scrp_pkg.sv =====
// Shared types, constants and codes of the strict CSV record parser.
package scrp_pkg;

  localparam int FIELD_COUNT    = 3;
  localparam int MAX_CELL_BYTES = 4096;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam int QCNT_W         = 3;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_COMMA,
    CLS_LF,
    CLS_CR,
    CLS_QUOTE,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    EV_CELL   = 2'd0,
    EV_RECORD = 2'd1,
    EV_END    = 2'd2,
    EV_ERROR  = 2'd3
  } ev_t;

  typedef enum logic [3:0] {
    ERR_ZERO_BYTE   = 4'd0,
    ERR_EXTRA_FIELD = 4'd1,
    ERR_BARE_CR     = 4'd2,
    ERR_JUNK_QUOTE  = 4'd3,
    ERR_STRAY_QUOTE = 4'd4,
    ERR_TOO_LONG    = 4'd5,
    ERR_OPEN_QUOTE  = 4'd6,
    ERR_READ        = 4'd7,
    ERR_FIELD_COUNT = 4'd8
  } cause_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       read_failed;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic   not_empty;
    logic   full;
  } qstat_t;

endpackage

// ===== rtl/scrp_front.sv =====
// Front stage: takes input requests, classifies the byte and hands them to the queue.
module scrp_front import scrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  input  logic       in_read_failed,
  input  qstat_t     qstat,
  output logic       push,
  output item_t      push_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  cls_t  cls;

  always_comb begin
    if (in_data_byte == 8'd0) begin
      cls = CLS_ZERO;
    end else if (in_data_byte == CH_COMMA) begin
      cls = CLS_COMMA;
    end else if (in_data_byte == CH_LF) begin
      cls = CLS_LF;
    end else if (in_data_byte == CH_CR) begin
      cls = CLS_CR;
    end else if (in_data_byte == CH_QUOTE) begin
      cls = CLS_QUOTE;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign push      = valid_r && !qstat.full;
  assign push_item = item_r;
  assign in_ready  = !valid_r || push;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind        <= in_kind;
      item_r.data_byte   <= in_data_byte;
      item_r.read_failed <= in_read_failed;
      item_r.cls         <= cls;
    end
  end

endmodule

// ===== rtl/scrp_queue.sv =====
// Short queue of classified requests between the front and the back stages.
module scrp_queue import scrp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head_item,
  output qstat_t qstat
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign qstat.not_empty = (count_r != '0);
  assign qstat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_item       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && count_r == '0))
    else $error("queue popped while empty");
`endif

endmodule

// ===== rtl/scrp_back.sv =====
// Back stage: record parsing state, cell length check and the output register.
module scrp_back import scrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_cell_limit,
  input  qstat_t      qstat,
  input  item_t       head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_column,
  output logic [11:0] out_position,
  output logic [7:0]  out_cell_byte,
  output logic [3:0]  out_error_cause
);

  logic [12:0] cell_limit_r;
  logic [1:0]  field_index_r, field_index_nxt;
  logic        in_quotes_r, in_quotes_nxt;
  logic        quote_closed_r, quote_closed_nxt;
  logic        record_started_r, record_started_nxt;
  logic [12:0] cell_length_r, cell_length_nxt;
  logic        quote_pending_r, quote_pending_nxt;
  logic        cr_pending_r, cr_pending_nxt;

  logic        out_valid_r, out_valid_nxt;
  ev_t         ev_r;
  logic [1:0]  column_r;
  logic [11:0] position_r;
  logic [7:0]  cell_byte_r;
  cause_t      cause_r;

  logic        emit;
  ev_t         ev;
  cause_t      cause;
  logic        do_store;
  logic        do_finish;
  logic        outside;
  logic [12:0] lim;
  logic [1:0]  st_col;
  logic [11:0] st_pos;

  assign cfg_ready = 1'b1;
  assign pop       = qstat.not_empty && (!out_valid_r || out_ready);
  assign lim       = (cell_limit_r > 13'(MAX_CELL_BYTES)) ? 13'(MAX_CELL_BYTES) : cell_limit_r;

  always_comb begin
    field_index_nxt    = field_index_r;
    in_quotes_nxt      = in_quotes_r;
    quote_closed_nxt   = quote_closed_r;
    record_started_nxt = record_started_r;
    cell_length_nxt    = cell_length_r;
    quote_pending_nxt  = quote_pending_r;
    cr_pending_nxt     = cr_pending_r;
    emit      = 1'b0;
    ev        = EV_CELL;
    cause     = ERR_ZERO_BYTE;
    do_store  = 1'b0;
    do_finish = 1'b0;
    outside   = 1'b0;
    st_col    = '0;
    st_pos    = '0;

    if (head_item.kind) begin
      if (cr_pending_r) begin
        emit = 1'b1; ev = EV_ERROR; cause = ERR_BARE_CR;
      end else if (head_item.read_failed) begin
        emit = 1'b1; ev = EV_ERROR; cause = ERR_READ;
      end else if (in_quotes_r && !quote_pending_r) begin
        emit = 1'b1; ev = EV_ERROR; cause = ERR_OPEN_QUOTE;
      end else if (!record_started_r) begin
        emit = 1'b1; ev = EV_END;
      end else begin
        do_finish = 1'b1;
      end
    end else begin
      record_started_nxt = 1'b1;
      if (cr_pending_r) begin
        cr_pending_nxt = 1'b0;
        if (head_item.cls == CLS_LF) begin
          do_finish = 1'b1;
        end else begin
          emit = 1'b1; ev = EV_ERROR; cause = ERR_BARE_CR;
        end
      end else if (head_item.cls == CLS_ZERO) begin
        emit = 1'b1; ev = EV_ERROR; cause = ERR_ZERO_BYTE;
      end else begin
        if (quote_pending_r) begin
          quote_pending_nxt = 1'b0;
          if (head_item.cls == CLS_QUOTE) begin
            do_store = 1'b1;
          end else begin
            in_quotes_nxt    = 1'b0;
            quote_closed_nxt = 1'b1;
            outside          = 1'b1;
          end
        end else if (in_quotes_r) begin
          if (head_item.cls == CLS_QUOTE) begin
            quote_pending_nxt = 1'b1;
          end else begin
            do_store = 1'b1;
          end
        end else begin
          outside = 1'b1;
        end

        if (outside) begin
          unique case (head_item.cls)
            CLS_COMMA: begin
              if (field_index_r >= 2'(FIELD_COUNT - 1)) begin
                emit = 1'b1; ev = EV_ERROR; cause = ERR_EXTRA_FIELD;
              end else begin
                field_index_nxt  = field_index_r + 1'b1;
                cell_length_nxt  = '0;
                quote_closed_nxt = 1'b0;
              end
            end
            CLS_LF: begin
              do_finish = 1'b1;
            end
            CLS_CR: begin
              cr_pending_nxt = 1'b1;
            end
            default: begin
              if (quote_closed_nxt) begin
                emit = 1'b1; ev = EV_ERROR; cause = ERR_JUNK_QUOTE;
              end else if (head_item.cls == CLS_QUOTE) begin
                if (cell_length_r != '0) begin
                  emit = 1'b1; ev = EV_ERROR; cause = ERR_STRAY_QUOTE;
                end else begin
                  in_quotes_nxt = 1'b1;
                end
              end else begin
                do_store = 1'b1;
              end
            end
          endcase
        end
      end
    end

    // A stored byte either goes out with its place in the cell or overflows it.
    if (do_store) begin
      emit = 1'b1;
      if (cell_length_r >= lim) begin
        ev = EV_ERROR; cause = ERR_TOO_LONG;
      end else begin
        ev              = EV_CELL;
        st_col          = field_index_r;
        st_pos          = cell_length_r[11:0];
        cell_length_nxt = cell_length_r + 1'b1;
      end
    end

    if (do_finish) begin
      emit = 1'b1;
      if (field_index_r == 2'(FIELD_COUNT - 1)) begin
        ev = EV_RECORD;
      end else begin
        ev = EV_ERROR; cause = ERR_FIELD_COUNT;
      end
    end

    // Any event other than a cell byte starts a fresh record.
    if (emit && ev != EV_CELL) begin
      field_index_nxt    = '0;
      in_quotes_nxt      = 1'b0;
      quote_closed_nxt   = 1'b0;
      record_started_nxt = 1'b0;
      cell_length_nxt    = '0;
      quote_pending_nxt  = 1'b0;
      cr_pending_nxt     = 1'b0;
    end
  end

  always_comb begin
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_limit_r     <= 13'(MAX_CELL_BYTES);
      field_index_r    <= '0;
      in_quotes_r      <= 1'b0;
      quote_closed_r   <= 1'b0;
      record_started_r <= 1'b0;
      cell_length_r    <= '0;
      quote_pending_r  <= 1'b0;
      cr_pending_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cell_limit_r <= cfg_cell_limit;
      end
      if (pop) begin
        field_index_r    <= field_index_nxt;
        in_quotes_r      <= in_quotes_nxt;
        quote_closed_r   <= quote_closed_nxt;
        record_started_r <= record_started_nxt;
        cell_length_r    <= cell_length_nxt;
        quote_pending_r  <= quote_pending_nxt;
        cr_pending_r     <= cr_pending_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      ev_r        <= ev;
      column_r    <= st_col;
      position_r  <= st_pos;
      cell_byte_r <= (ev == EV_CELL) ? head_item.data_byte : 8'd0;
      cause_r     <= (ev == EV_ERROR) ? cause : ERR_ZERO_BYTE;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = ev_r;
  assign out_column      = column_r;
  assign out_position    = position_r;
  assign out_cell_byte   = cell_byte_r;
  assign out_error_cause = cause_r;

`ifndef ASSERT_OFF
  a_quote_pending_inside: assert property (@(posedge clk) disable iff (!rst_n)
    quote_pending_r |-> in_quotes_r)
    else $error("pending quote held outside a quoted cell");
  a_cr_outside: assert property (@(posedge clk) disable iff (!rst_n)
    cr_pending_r |-> (!in_quotes_r && !quote_pending_r))
    else $error("pending CR held inside a quoted cell");
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cell_length_r <= 13'(MAX_CELL_BYTES))
    else $error("cell length beyond the largest cell");
`endif

endmodule

// ===== rtl/strict_csv_record_parser.sv =====
// Top level of the strict CSV record parser: front stage, queue and back stage.
//
// Usage: bytes of a CSV stream arrive one request at a time on the in_ channel
// (in_kind 0 with in_data_byte), and the stream is closed by a request with
// in_kind 1, carrying in_read_failed if the source reported an error. Results
// leave on the out_ channel: one request per stored cell byte (with its column
// and position), one per completed record, one for a clean end of input, or
// one numbered error. Many inputs, such as commas and opening quotes, give no
// result at all. The cfg_ channel sets the cell length limit; it is always
// ready; the user must write it only while the block is idle, and the block
// itself does not enforce this. A result passes the front register, the queue
// and the result register. One input request per cycle is sustained while
// out_ready is high; the back stage record state update sets that rate.
// A four-entry queue between the classifying front stage and the parsing back
// stage lets either side stall on its own. When the receiver stalls, the
// result register holds its request, the queue fills and in_ready falls.
// Synchronous reset clears the record state, empties the queue and restores
// the cell limit to 4096; no result is pending after reset.
module strict_csv_record_parser import scrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        in_read_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_column,
  output logic [11:0] out_position,
  output logic [7:0]  out_cell_byte,
  output logic [3:0]  out_error_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_cell_limit
);

  // Classified requests travel as one struct from front to queue to back.
  logic   push;
  logic   pop;
  item_t  push_item;
  item_t  head_item;
  qstat_t qstat;

  scrp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .in_read_failed (in_read_failed),
    .qstat          (qstat),
    .push           (push),
    .push_item      (push_item)
  );

  scrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // The back stage pops whenever the queue holds a request and its result register is free or being emptied.
  scrp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_cell_limit  (cfg_cell_limit),
    .qstat           (qstat),
    .head_item       (head_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_column      (out_column),
    .out_position    (out_position),
    .out_cell_byte   (out_cell_byte),
    .out_error_cause (out_error_cause)
  );

endmodule
